/* hw/rtl/lsc_pkg.sv */
// Shared constants, codes and types of the level-step command sequencer.
package lsc_pkg;

  localparam int LEVEL_W  = 5;
  localparam int CODE_W   = 8;
  localparam int TICK_W   = 8;
  localparam int SEQ_W    = 4;
  localparam int REP_W    = 4;
  localparam int FUNC_W   = 2;
  localparam int CNT_W    = 4;
  localparam int WORD_W   = 20;
  localparam int ADDR_W   = 5;
  localparam int PDATA_W  = 32;
  localparam int MAX_PKTS = 11;

  localparam logic signed [LEVEL_W-1:0] MAX_LEVEL_A   = 5'sd10;
  localparam logic signed [LEVEL_W-1:0] MAX_LEVEL_B   = 5'sd6;
  localparam logic signed [LEVEL_W-1:0] LEVEL_UNKNOWN = -5'sd2;

  localparam logic [7:0] SYNC_BYTE = 8'hBD;

  // Function codes carried in tuser.
  localparam logic [FUNC_W-1:0] FUNC_SET_A     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_B     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POWER_OFF = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_KEEPALIVE = 2'd3;

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_CODE_A_STEP    = 3'd0;
  localparam logic [2:0] REG_CODE_A_OFF     = 3'd1;
  localparam logic [2:0] REG_CODE_B_STEP    = 3'd2;
  localparam logic [2:0] REG_CODE_B_OFF     = 3'd3;
  localparam logic [2:0] REG_CODE_POWER_OFF = 3'd4;
  localparam logic [2:0] REG_REPEAT_COUNT   = 3'd5;
  localparam logic [2:0] REG_KEEPALIVE_INTV = 3'd6;

  localparam logic [REP_W-1:0]  REPEAT_COUNT_RST = 4'd1;
  localparam logic [TICK_W-1:0] KEEPALIVE_RST    = 8'd10;

  typedef struct packed {
    logic [CODE_W-1:0] code_a_step;
    logic [CODE_W-1:0] code_a_off;
    logic [CODE_W-1:0] code_b_step;
    logic [CODE_W-1:0] code_b_off;
    logic [CODE_W-1:0] code_power_off;
    logic [REP_W-1:0]  repeat_count;
    logic [TICK_W-1:0] keepalive_interval;
  } cfg_t;

  typedef struct packed {
    logic take_in;  // latch the input beat
    logic plan;     // evaluate the request, update channel state
    logic load;     // build the next packet into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic pkts_left;  // at least one packet still to build
  } dp_status_t;

  typedef struct packed {
    logic                        ignore;
    logic signed [LEVEL_W-1:0]   new_level;
    logic                        off_first;
    logic [CNT_W-1:0]            steps;
    logic                        stamp;
  } set_plan_t;

endpackage

/* hw/rtl/lsc_regs.sv */
// Configuration register file with its APB-style port.
module lsc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsc_pkg::ADDR_W-1:0]    paddr,
  input  logic [lsc_pkg::PDATA_W-1:0]   pwdata,
  output logic [lsc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output lsc_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_a_step        <= '0;
      cfg.code_a_off         <= '0;
      cfg.code_b_step        <= '0;
      cfg.code_b_off         <= '0;
      cfg.code_power_off     <= '0;
      cfg.repeat_count       <= lsc_pkg::REPEAT_COUNT_RST;
      cfg.keepalive_interval <= lsc_pkg::KEEPALIVE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lsc_pkg::REG_CODE_A_STEP:    cfg.code_a_step        <= pwdata[7:0];
        lsc_pkg::REG_CODE_A_OFF:     cfg.code_a_off         <= pwdata[7:0];
        lsc_pkg::REG_CODE_B_STEP:    cfg.code_b_step        <= pwdata[7:0];
        lsc_pkg::REG_CODE_B_OFF:     cfg.code_b_off         <= pwdata[7:0];
        lsc_pkg::REG_CODE_POWER_OFF: cfg.code_power_off     <= pwdata[7:0];
        lsc_pkg::REG_REPEAT_COUNT:   cfg.repeat_count       <= pwdata[3:0];
        lsc_pkg::REG_KEEPALIVE_INTV: cfg.keepalive_interval <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      lsc_pkg::REG_CODE_A_STEP:    prdata[7:0] = cfg.code_a_step;
      lsc_pkg::REG_CODE_A_OFF:     prdata[7:0] = cfg.code_a_off;
      lsc_pkg::REG_CODE_B_STEP:    prdata[7:0] = cfg.code_b_step;
      lsc_pkg::REG_CODE_B_OFF:     prdata[7:0] = cfg.code_b_off;
      lsc_pkg::REG_CODE_POWER_OFF: prdata[7:0] = cfg.code_power_off;
      lsc_pkg::REG_REPEAT_COUNT:   prdata[3:0] = cfg.repeat_count;
      lsc_pkg::REG_KEEPALIVE_INTV: prdata[7:0] = cfg.keepalive_interval;
      default:                     prdata      = '0;
    endcase
  end

endmodule

/* hw/rtl/lsc_ctrl.sv */
// Controller state machine: input latch, plan, packet build and send.
module lsc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  lsc_pkg::dp_status_t    status,
  output lsc_pkg::ctrl_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PLAN = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_SEND);

  always_comb begin
    state_next  = state;
    cmd.take_in = 1'b0;
    cmd.plan    = 1'b0;
    cmd.load    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take_in = 1'b1;
          state_next  = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.pkts_left) begin
          cmd.load   = 1'b1;
          state_next = ST_SEND;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SEND: begin
        // refill the output register on the same edge the beat leaves
        if (m_tready) begin
          if (status.pkts_left) begin
            cmd.load = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/lsc_dp.sv */
// Datapath: channel levels, activity stamp, sequence counter and packet builder.
module lsc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  lsc_pkg::ctrl_cmd_t                  cmd,
  output lsc_pkg::dp_status_t                 status,
  input  lsc_pkg::cfg_t                       cfg,
  input  logic [lsc_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [lsc_pkg::LEVEL_W-1:0]  in_level,
  input  logic [lsc_pkg::TICK_W-1:0]          in_tick,
  output logic [lsc_pkg::CODE_W-1:0]          cmd_code,
  output logic [lsc_pkg::WORD_W-1:0]          packet_word,
  output logic [lsc_pkg::REP_W-1:0]           repeats,
  output logic                                last
);

  // latched request
  logic [lsc_pkg::FUNC_W-1:0]         func_q;
  logic signed [lsc_pkg::LEVEL_W-1:0] level_q;
  logic [lsc_pkg::TICK_W-1:0]         tick_q;

  // channel state
  logic signed [lsc_pkg::LEVEL_W-1:0] level_a;
  logic signed [lsc_pkg::LEVEL_W-1:0] level_b;
  logic [lsc_pkg::TICK_W-1:0]         last_act;
  logic [lsc_pkg::SEQ_W-1:0]          seq;

  logic signed [lsc_pkg::LEVEL_W-1:0] level_a_next;
  logic signed [lsc_pkg::LEVEL_W-1:0] level_b_next;
  logic [lsc_pkg::TICK_W-1:0]         last_act_next;

  // packet plan: an optional first packet, then a run of identical ones
  logic                         first_pend;
  logic [lsc_pkg::CNT_W-1:0]    pkt_left;
  logic [lsc_pkg::CODE_W-1:0]   first_code;
  logic [lsc_pkg::CODE_W-1:0]   rest_code;

  logic                         plan_first;
  logic [lsc_pkg::CNT_W-1:0]    plan_rest;
  logic [lsc_pkg::CODE_W-1:0]   plan_first_code;
  logic [lsc_pkg::CODE_W-1:0]   plan_rest_code;

  logic [lsc_pkg::SEQ_W-1:0]    seq_inc;
  logic [lsc_pkg::TICK_W-1:0]   idle_ticks;
  lsc_pkg::set_plan_t           sp_a;
  lsc_pkg::set_plan_t           sp_b;

  logic [lsc_pkg::CODE_W-1:0]   out_code;
  logic [lsc_pkg::SEQ_W-1:0]    out_seq;

  function automatic lsc_pkg::set_plan_t set_eval(
    input logic signed [lsc_pkg::LEVEL_W-1:0] curr,
    input logic signed [lsc_pkg::LEVEL_W-1:0] req,
    input logic signed [lsc_pkg::LEVEL_W-1:0] max_lvl
  );
    lsc_pkg::set_plan_t                 p;
    logic signed [lsc_pkg::LEVEL_W-1:0] reqc;
    logic signed [lsc_pkg::LEVEL_W-1:0] diff;
    logic                               up;
    reqc        = (req < 0 || req > max_lvl) ? '0 : req;
    up          = (reqc > curr) && (curr >= 0);
    diff        = reqc - curr;
    p.ignore    = (req == curr);
    p.new_level = reqc;
    p.off_first = !up;
    p.steps     = up ? diff[3:0] : reqc[3:0];
    p.stamp     = (curr != 0);
    return p;
  endfunction

  assign sp_a       = set_eval(level_a, level_q, lsc_pkg::MAX_LEVEL_A);
  assign sp_b       = set_eval(level_b, level_q, lsc_pkg::MAX_LEVEL_B);
  assign idle_ticks = tick_q - last_act;
  assign seq_inc    = seq + 1'b1;

  always_comb begin
    level_a_next    = level_a;
    level_b_next    = level_b;
    last_act_next   = last_act;
    plan_first      = 1'b0;
    plan_rest       = '0;
    plan_first_code = '0;
    plan_rest_code  = '0;
    case (func_q)
      lsc_pkg::FUNC_SET_A: begin
        if (!sp_a.ignore) begin
          level_a_next    = sp_a.new_level;
          plan_first      = sp_a.off_first;
          plan_first_code = cfg.code_a_off;
          plan_rest_code  = cfg.code_a_step;
          plan_rest       = sp_a.steps;
          if (sp_a.stamp) begin
            last_act_next = tick_q;
          end
        end
      end
      lsc_pkg::FUNC_SET_B: begin
        if (!sp_b.ignore) begin
          level_b_next    = sp_b.new_level;
          plan_first      = sp_b.off_first;
          plan_first_code = cfg.code_b_off;
          plan_rest_code  = cfg.code_b_step;
          plan_rest       = sp_b.steps;
          if (sp_b.stamp) begin
            last_act_next = tick_q;
          end
        end
      end
      lsc_pkg::FUNC_POWER_OFF: begin
        plan_first      = 1'b1;
        plan_first_code = cfg.code_power_off;
        level_a_next    = lsc_pkg::LEVEL_UNKNOWN;
        level_b_next    = lsc_pkg::LEVEL_UNKNOWN;
      end
      lsc_pkg::FUNC_KEEPALIVE: begin
        if (idle_ticks >= cfg.keepalive_interval) begin
          last_act_next = tick_q;
          // wake an idle receiver: step A up, then off again
          if (level_a <= 0 && level_b <= 0) begin
            plan_first      = 1'b1;
            plan_first_code = cfg.code_a_step;
            plan_rest_code  = cfg.code_a_off;
            plan_rest       = 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_a    <= lsc_pkg::LEVEL_UNKNOWN;
      level_b    <= lsc_pkg::LEVEL_UNKNOWN;
      last_act   <= '0;
      seq        <= '0;
      first_pend <= 1'b0;
      pkt_left   <= '0;
    end else if (cmd.plan) begin
      level_a    <= level_a_next;
      level_b    <= level_b_next;
      last_act   <= last_act_next;
      first_pend <= plan_first;
      pkt_left   <= plan_rest + lsc_pkg::CNT_W'(plan_first);
    end else if (cmd.load) begin
      seq        <= seq_inc;
      first_pend <= 1'b0;
      pkt_left   <= pkt_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      func_q  <= in_func;
      level_q <= in_level;
      tick_q  <= in_tick;
    end
    if (cmd.plan) begin
      first_code <= plan_first_code;
      rest_code  <= plan_rest_code;
    end
    if (cmd.load) begin
      out_code <= first_pend ? first_code : rest_code;
      out_seq  <= seq_inc;
      repeats  <= cfg.repeat_count;
      last     <= (pkt_left == 4'd1);
    end
  end

  assign status.pkts_left = (pkt_left != '0);
  assign cmd_code         = out_code;
  assign packet_word      = {out_code, lsc_pkg::SYNC_BYTE, out_seq};

  a_pkt_bound: assert property (@(posedge clk) disable iff (rst)
    pkt_left <= lsc_pkg::CNT_W'(lsc_pkg::MAX_PKTS))
    else $error("packet count exceeds the largest plan");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (seq == $past(seq) + 1'b1) && (out_seq == seq))
    else $error("sequence number not advanced with the packet");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (last == (pkt_left == '0)))
    else $error("last flag disagrees with remaining packets");

  a_level_a_range: assert property (@(posedge clk) disable iff (rst)
    level_a == lsc_pkg::LEVEL_UNKNOWN || (level_a >= 0 && level_a <= lsc_pkg::MAX_LEVEL_A))
    else $error("channel A level out of range");

  a_level_b_range: assert property (@(posedge clk) disable iff (rst)
    level_b == lsc_pkg::LEVEL_UNKNOWN || (level_b >= 0 && level_b <= lsc_pkg::MAX_LEVEL_B))
    else $error("channel B level out of range");

endmodule

/* hw/rtl/level_step_command_sequencer.sv */
// Level-step command sequencer: top level joining registers, controller and datapath.
//
// Takes one request beat at a time (set channel A, set channel B, power off,
// keepalive check) and turns it into up to eleven command packets. A request
// is latched in ST_IDLE, evaluated against the stored channel levels in
// ST_PLAN, and the first packet is built in ST_LOAD; after that one packet
// leaves per cycle while m_tready is high, the output register being refilled
// on the edge its beat is taken. A request holds s_tready low until all of its
// packets have been taken, so no new request is accepted before then; there is
// a single packet builder with one shared sequence counter. Packets carry the
// code in bits 19:12 of the packet word, 0xBD in 11:4 and a 4-bit sequence
// number that advances before each packet. Write registers only while idle.
module level_step_command_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // level[4:0], now_tick[12:5], zero fill
  input  logic [1:0]                   s_tuser,   // func[1:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,   // cmd_code[7:0], packet_word[27:8], repeats[31:28]
  output logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [lsc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  lsc_pkg::cfg_t        cfg;
  lsc_pkg::ctrl_cmd_t   cmd;
  lsc_pkg::dp_status_t  status;

  logic [lsc_pkg::CODE_W-1:0] cmd_code;
  logic [lsc_pkg::WORD_W-1:0] packet_word;
  logic [lsc_pkg::REP_W-1:0]  repeats;

  lsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lsc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg         (cfg),
    .in_func     (s_tuser),
    .in_level    (s_tdata[4:0]),
    .in_tick     (s_tdata[12:5]),
    .cmd_code    (cmd_code),
    .packet_word (packet_word),
    .repeats     (repeats),
    .last        (m_tlast)
  );

  assign m_tdata = {repeats, packet_word, cmd_code};

endmodule
